// ===== rtl/ctl_pkg.sv =====
// ---------------------------------------------------------------------------
// ctl_pkg
// Shared types, codes and the keyword table for the C token lexer.
// ---------------------------------------------------------------------------
package ctl_pkg;

  localparam int RES_MAX  = 3;
  localparam int KW_COUNT = 34;

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_NUMBER = 3'd1,
    MODE_STRING = 3'd2,
    MODE_CHAR   = 3'd3,
    MODE_IDENT  = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    KIND_NUMBER  = 3'd0,
    KIND_STRING  = 3'd1,
    KIND_KEYWORD = 3'd2,
    KIND_CHAR    = 3'd3,
    KIND_IDENT   = 3'd4,
    KIND_PUNC    = 3'd5,
    KIND_OP      = 3'd6
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic        is_end;
    logic [31:0] start;
    logic [15:0] length;
    logic        unterm;
    logic        last;
  } result_t;

  // first character in the top byte, zero padded
  localparam logic [63:0] KW_TABLE [KW_COUNT] = '{
    {"auto", 32'h0}, {"break", 24'h0}, {"case", 32'h0}, {"char", 32'h0},
    {"const", 24'h0}, {"continue"}, {"default", 8'h0}, {"do", 48'h0},
    {"double", 16'h0}, {"else", 32'h0}, {"enum", 32'h0}, {"extern", 16'h0},
    {"float", 24'h0}, {"for", 40'h0}, {"goto", 32'h0}, {"if", 48'h0},
    {"inline", 16'h0}, {"int", 40'h0}, {"long", 32'h0}, {"register"},
    {"restrict"}, {"return", 16'h0}, {"short", 24'h0}, {"signed", 16'h0},
    {"sizeof", 16'h0}, {"static", 16'h0}, {"struct", 16'h0},
    {"switch", 16'h0}, {"typedef", 8'h0}, {"union", 24'h0},
    {"unsigned"}, {"void", 32'h0}, {"volatile"}, {"while", 24'h0}
  };

  // word holds the first eight bytes, byte 0 in the low bits, unused bytes zero
  function automatic logic kw_match(input logic [63:0] word, input logic [15:0] len);
    logic [63:0] rev;
    logic        hit;
    hit = 1'b0;
    for (int i = 0; i < 8; i++) begin
      rev[8*(7-i) +: 8] = word[8*i +: 8];
    end
    for (int k = 0; k < KW_COUNT; k++) begin
      if (rev == KW_TABLE[k]) begin
        hit = 1'b1;
      end
    end
    return hit && (len != 16'd0) && (len <= 16'd8);
  endfunction

endpackage

// ===== rtl/ctl_lexer_core.sv =====
// ---------------------------------------------------------------------------
// ctl_lexer_core
// Byte classifier and token state; produces up to three results per byte.
// ---------------------------------------------------------------------------
module ctl_lexer_core
  import ctl_pkg::*;
#(
  parameter int KEYWORD_MAX_LEN = 8,
  parameter int OFFSET_BITS     = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      step,
  input  logic [7:0]                char_in,
  input  logic                      end_of_text,
  output result_t [RES_MAX-1:0]     res,
  output logic [1:0]                res_count
);

  localparam int PW   = KEYWORD_MAX_LEN * 8;
  localparam int IDXW = $clog2(KEYWORD_MAX_LEN);
  localparam int EXTW = (OFFSET_BITS > 32) ? OFFSET_BITS : 32;

  mode_t                  mode_r, mode_nxt, mid_mode, new_mode;
  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;
  logic [OFFSET_BITS-1:0] start_r, start_nxt, mid_start;
  logic [15:0]            len_r, len_nxt, mid_len, len_inc;
  logic [PW-1:0]          prefix_r, prefix_nxt, mid_prefix;

  logic c_blank, c_digit, c_op, c_punc, c_dq, c_sq;
  logic in_lit, lit_end, cont, close_hit, lit_close, starts;

  function automatic logic [31:0] to32(input logic [OFFSET_BITS-1:0] v);
    logic [EXTW-1:0] ext;
    ext = EXTW'(v);
    return ext[31:0];
  endfunction

  always_comb begin
    c_blank = (char_in == 8'h20) || (char_in == 8'h09) || (char_in == 8'h0A);
    c_digit = (char_in >= "0") && (char_in <= "9");
    c_op    = (char_in inside {"+", "-", "*", "/", "%", "=", "&", "|", "!"});
    c_punc  = (char_in inside {",", ";", "(", ")", "{", "}", "[", "]"});
    c_dq    = (char_in == 8'h22);
    c_sq    = (char_in == 8'h27);
  end

  assign len_inc   = (len_r == 16'hFFFF) ? len_r : len_r + 16'd1;
  assign in_lit    = (mode_r == MODE_STRING) || (mode_r == MODE_CHAR);
  assign lit_end   = ((mode_r == MODE_STRING) && c_dq) || ((mode_r == MODE_CHAR) && c_sq);
  assign lit_close = in_lit && lit_end;
  assign cont      = in_lit ||
                     ((mode_r == MODE_NUMBER) && c_digit) ||
                     ((mode_r == MODE_IDENT) && !(c_blank || c_op || c_punc));
  assign close_hit = ((mode_r == MODE_NUMBER) && !c_digit) ||
                     ((mode_r == MODE_IDENT) && (c_blank || c_op || c_punc));
  assign starts    = !cont && !c_blank && !c_op && !c_punc;

  always_comb begin
    if (c_dq) begin
      new_mode = MODE_STRING;
    end else if (c_sq) begin
      new_mode = MODE_CHAR;
    end else if (c_digit) begin
      new_mode = MODE_NUMBER;
    end else begin
      new_mode = MODE_IDENT;
    end
  end

  // token state after this byte, before the end-of-text flush
  always_comb begin
    mid_mode   = mode_r;
    mid_start  = start_r;
    mid_len    = len_r;
    mid_prefix = prefix_r;
    if (cont) begin
      mid_len = len_inc;
      if (lit_close) begin
        mid_mode = MODE_IDLE;
      end
      if ((mode_r == MODE_IDENT) && (len_r < 16'(KEYWORD_MAX_LEN))) begin
        mid_prefix[len_r[IDXW-1:0]*8 +: 8] = char_in;
      end
    end else if (starts) begin
      mid_mode        = new_mode;
      mid_start       = pos_r;
      mid_len         = 16'd1;
      mid_prefix      = '0;
      mid_prefix[7:0] = char_in;
    end else begin
      mid_mode = MODE_IDLE;
    end
  end

  // next state
  always_comb begin
    if (end_of_text) begin
      mode_nxt   = MODE_IDLE;
      pos_nxt    = '0;
      start_nxt  = '0;
      len_nxt    = '0;
      prefix_nxt = '0;
    end else begin
      mode_nxt   = mid_mode;
      pos_nxt    = pos_r + OFFSET_BITS'(1);
      start_nxt  = mid_start;
      len_nxt    = mid_len;
      prefix_nxt = mid_prefix;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      pos_r    <= '0;
      start_r  <= '0;
      len_r    <= '0;
      prefix_r <= '0;
    end else if (step) begin
      mode_r   <= mode_nxt;
      pos_r    <= pos_nxt;
      start_r  <= start_nxt;
      len_r    <= len_nxt;
      prefix_r <= prefix_nxt;
    end
  end

  // results: closed token, single-char or flushed token, end marker
  always_comb begin
    result_t    ra, rb, rc;
    logic       va, vb, vc;
    logic [1:0] n;
    ra = '0;
    rb = '0;
    rc = '0;
    va = close_hit || lit_close;
    ra.start  = to32(start_r);
    ra.length = lit_close ? len_inc : len_r;
    case (mode_r)
      MODE_NUMBER: ra.kind = KIND_NUMBER;
      MODE_STRING: ra.kind = KIND_STRING;
      MODE_CHAR:   ra.kind = KIND_CHAR;
      MODE_IDENT:  ra.kind = kw_match(prefix_r[63:0], len_r) ? KIND_KEYWORD : KIND_IDENT;
      default:     ra.kind = KIND_NUMBER;
    endcase

    vb = 1'b0;
    if (!cont && (c_punc || c_op)) begin
      vb        = 1'b1;
      rb.kind   = c_punc ? KIND_PUNC : KIND_OP;
      rb.start  = to32(pos_r);
      rb.length = 16'd1;
    end else if (end_of_text && (mid_mode != MODE_IDLE)) begin
      vb        = 1'b1;
      rb.start  = to32(mid_start);
      rb.length = mid_len;
      case (mid_mode)
        MODE_NUMBER: rb.kind = KIND_NUMBER;
        MODE_STRING: rb.kind = KIND_STRING;
        MODE_CHAR:   rb.kind = KIND_CHAR;
        MODE_IDENT:  rb.kind = kw_match(mid_prefix[63:0], mid_len) ? KIND_KEYWORD : KIND_IDENT;
        default:     rb.kind = KIND_NUMBER;
      endcase
      rb.unterm = (mid_mode == MODE_STRING) || (mid_mode == MODE_CHAR);
    end

    vc        = end_of_text;
    rc.is_end = 1'b1;
    rc.last   = 1'b1;

    // pack valid results to the low slots
    res = '0;
    n   = 2'd0;
    if (va) begin
      ra.last = !vb && !vc;
      res[n]  = ra;
      n       = n + 2'd1;
    end
    if (vb) begin
      rb.last = !vc;
      res[n]  = rb;
      n       = n + 2'd1;
    end
    if (vc) begin
      res[n] = rc;
      n      = n + 2'd1;
    end
    res_count = n;
  end

endmodule

// ===== rtl/ctl_result_queue.sv =====
// ---------------------------------------------------------------------------
// ctl_result_queue
// Four-entry shift queue: takes up to three results a cycle, hands out one.
// ---------------------------------------------------------------------------
module ctl_result_queue
  import ctl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  result_t [RES_MAX-1:0] push_res,
  input  logic [1:0]            push_n,
  output logic                  room,
  output logic                  head_valid,
  output result_t               head,
  input  logic                  pop_ready
);

  localparam int QDEPTH = 4;
  localparam int CW     = $clog2(QDEPTH + 1);

  result_t [QDEPTH-1:0] q_r, q_nxt;
  logic [CW-1:0]        count_r, count_nxt, base;
  logic                 pop;

  assign head_valid = (count_r != '0);
  assign head       = q_r[0];
  assign pop        = head_valid && pop_ready;
  // a byte may bring three results
  assign room       = (count_r <= CW'(QDEPTH - RES_MAX));
  assign base       = count_r - CW'(pop);
  assign count_nxt  = base + CW'(push_n);

  always_comb begin
    logic [CW-1:0] rel;
    for (int j = 0; j < QDEPTH; j++) begin
      if (pop && (j < QDEPTH - 1)) begin
        q_nxt[j] = q_r[j+1];
      end else begin
        q_nxt[j] = q_r[j];
      end
      rel = CW'(j) - base;
      if ((CW'(j) >= base) && (rel < CW'(push_n))) begin
        q_nxt[j] = push_res[rel[1:0]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

endmodule

// ===== rtl/c_token_lexer_unit.sv =====
// ---------------------------------------------------------------------------
// c_token_lexer_unit
// Streaming C lexer: one source byte per beat in, one token per beat out.
// ---------------------------------------------------------------------------
// output: a byte's results are registered in the result queue and leave from its head
// throughput: one byte per cycle while each byte yields at most one token and
//   out_tready stays high; a byte yielding two or three tokens holds in_tready
//   low until the four-entry result queue drains to one entry
// reset: synchronous; lexer returns to idle, offset to zero, queue empties
module c_token_lexer_unit
  import ctl_pkg::*;
#(
  parameter int KEYWORD_MAX_LEN = 8,
  parameter int OFFSET_BITS     = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // char_in
  input  logic        in_tlast,   // end_of_text
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // token_start[31:0], token_length[47:32],
                                  // unterminated[48], zero fill
  output logic [3:0]  out_tuser,  // token_kind[2:0], is_end_token[3]
  output logic        out_tlast   // last_result
);

  result_t [RES_MAX-1:0] res;
  logic [1:0]            res_count;
  logic                  in_fire;
  result_t               head;

  assign in_fire = in_tvalid && in_tready;

  ctl_lexer_core #(
    .KEYWORD_MAX_LEN (KEYWORD_MAX_LEN),
    .OFFSET_BITS     (OFFSET_BITS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (in_fire),
    .char_in     (in_tdata),
    .end_of_text (in_tlast),
    .res         (res),
    .res_count   (res_count)
  );

  ctl_result_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_res   (res),
    .push_n     (in_fire ? res_count : 2'd0),
    .room       (in_tready),
    .head_valid (out_tvalid),
    .head       (head),
    .pop_ready  (out_tready)
  );

  assign out_tdata = {7'd0, head.unterm, head.length, head.start};
  assign out_tuser = {head.is_end, head.kind};
  assign out_tlast = head.last;

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("queue empty but input stalled");

  a_end_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> out_tvalid)
    else $error("final byte produced no result");

  a_end_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[3] |-> out_tlast && (out_tdata == 56'd0) &&
    (out_tuser[2:0] == 3'd0))
    else $error("malformed end marker beat");

endmodule
